>>> rtl/bmhpq_pkg.sv
// Shared types, codes and defaults for the binary max-heap priority queue.
package bmhpq_pkg;

   localparam int DEF_CAPACITY  = 1024;
   localparam int DEF_KEY_WIDTH = 32;
   localparam int FIELD_W       = 32;
   localparam int COUNT_FIELD_W = 11;

   typedef enum logic [0:0] {
      KIND_INSERT  = 1'b0,
      KIND_EXTRACT = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_READ,
      ST_UP_CMP,
      ST_EX_LAST,
      ST_DN_READ_L,
      ST_DN_READ_R,
      ST_DN_CMP_R,
      ST_DN_CMP_K
   } state_type;

   typedef struct packed {
      kind_type                    kind;
      logic signed [FIELD_W-1:0]   key_value;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic signed [FIELD_W-1:0]   removed_value;
      logic signed [FIELD_W-1:0]   top_value;
      logic [COUNT_FIELD_W-1:0]    element_count;
   } rsp_type;

endpackage

>>> rtl/bmhpq_store.sv
// Single-port-write, single-port-read key memory with registered read data.
module bmhpq_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bmhpq_ctrl.sv
// Sift sequencer: walks the heap one level at a time around a single shared comparator.
module bmhpq_ctrl #(
   parameter int CAPACITY  = 1024,
   parameter int KEY_WIDTH = 32,
   parameter int ADDR_W    = 10,
   parameter int COUNT_W   = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bmhpq_pkg::req_type    req_data,
   output logic                  rsp_valid,
   output bmhpq_pkg::rsp_type    rsp_data,
   output logic                  mem_wr_en,
   output logic [ADDR_W-1:0]     mem_wr_addr,
   output logic [KEY_WIDTH-1:0]  mem_wr_data,
   output logic                  mem_rd_en,
   output logic [ADDR_W-1:0]     mem_rd_addr,
   input  logic [KEY_WIDTH-1:0]  mem_rd_data
);

   import bmhpq_pkg::*;

   localparam int CHILD_W = COUNT_W + 1;

   state_type                    state_ff, state_in;
   logic [COUNT_W-1:0]           count_ff, count_in;
   logic [COUNT_W-1:0]           pos_ff, pos_in;
   logic [COUNT_W-1:0]           best_pos_ff, best_pos_in;
   logic signed [KEY_WIDTH-1:0]  key_ff, key_in;
   logic signed [KEY_WIDTH-1:0]  best_ff, best_in;
   logic signed [KEY_WIDTH-1:0]  top_ff, top_in;
   logic signed [KEY_WIDTH-1:0]  removed_ff, removed_in;
   status_type                   status_ff, status_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic signed [KEY_WIDTH-1:0]  req_key;
   logic signed [KEY_WIDTH-1:0]  rd_key;
   logic signed [KEY_WIDTH-1:0]  cmp_a, cmp_b;
   logic                         cmp_gt;
   logic [CHILD_W-1:0]           left_pos, right_pos, count_ext;
   logic signed [FIELD_W-1:0]    top_field, removed_field;

   assign rd_key = signed'(mem_rd_data);

   // A key is the low KEY_WIDTH bits of the field; a wider store holds the field unsigned.
   if (KEY_WIDTH <= FIELD_W) begin : g_key_narrow
      assign req_key       = req_data.key_value[KEY_WIDTH-1:0];
      assign top_field     = FIELD_W'(top_ff);
      assign removed_field = FIELD_W'(removed_ff);
   end else begin : g_key_wide
      assign req_key       = {{(KEY_WIDTH-FIELD_W){1'b0}}, req_data.key_value};
      assign top_field     = top_ff[FIELD_W-1:0];
      assign removed_field = removed_ff[FIELD_W-1:0];
   end

   assign left_pos  = {pos_ff, 1'b0};
   assign right_pos = {pos_ff, 1'b1};
   assign count_ext = CHILD_W'(count_ff);

   // The one comparator of the block; its operands follow the sequencer state.
   always_comb begin
      unique case (state_ff)
         ST_DN_CMP_R: begin
            cmp_a = rd_key;
            cmp_b = best_ff;
         end
         ST_DN_CMP_K: begin
            cmp_a = best_ff;
            cmp_b = key_ff;
         end
         default: begin
            cmp_a = key_ff;
            cmp_b = rd_key;
         end
      endcase
   end

   assign cmp_gt = cmp_a > cmp_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      best_pos_ff <= best_pos_in;
      key_ff      <= key_in;
      best_ff     <= best_in;
      top_ff      <= top_in;
      removed_ff  <= removed_in;
      status_ff   <= status_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      best_pos_in  = best_pos_ff;
      key_in       = key_ff;
      best_in      = best_ff;
      top_in       = top_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ADDR_W'(pos_ff - 1'b1);
      mem_wr_data  = key_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ADDR_W'(left_pos - 1'b1);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               removed_in = '0;
               status_in  = STATUS_OK;
               if (req_data.kind == KIND_INSERT) begin
                  if (count_ff == COUNT_W'(CAPACITY)) begin
                     status_in    = STATUS_FULL;
                     rsp_valid_in = 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                     pos_in   = count_ff + 1'b1;
                     key_in   = req_key;
                     state_in = ST_UP_READ;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in    = STATUS_EMPTY;
                     rsp_valid_in = 1'b1;
                  end else if (count_ff == COUNT_W'(1)) begin
                     removed_in   = top_ff;
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end else begin
                     // Fetch the last element; it refills the root.
                     removed_in  = top_ff;
                     count_in    = count_ff - 1'b1;
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = ADDR_W'(count_ff - 1'b1);
                     state_in    = ST_EX_LAST;
                  end
               end
            end
         end

         ST_UP_READ: begin
            if (pos_ff == COUNT_W'(1)) begin
               mem_wr_en    = 1'b1;
               top_in       = key_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ADDR_W'((pos_ff >> 1) - 1'b1);
               state_in    = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            mem_wr_en = 1'b1;
            if (cmp_gt) begin
               // The parent moves down into the hole; the hole climbs.
               mem_wr_data = mem_rd_data;
               pos_in      = pos_ff >> 1;
               state_in    = ST_UP_READ;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_EX_LAST: begin
            key_in   = rd_key;
            pos_in   = COUNT_W'(1);
            state_in = ST_DN_READ_L;
         end

         ST_DN_READ_L: begin
            if (left_pos > count_ext) begin
               mem_wr_en = 1'b1;
               if (pos_ff == COUNT_W'(1)) begin
                  top_in = key_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = ST_DN_READ_R;
            end
         end

         ST_DN_READ_R: begin
            best_in     = rd_key;
            best_pos_in = COUNT_W'(left_pos);
            if (right_pos <= count_ext) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ADDR_W'(right_pos - 1'b1);
               state_in    = ST_DN_CMP_R;
            end else begin
               state_in = ST_DN_CMP_K;
            end
         end

         ST_DN_CMP_R: begin
            // The right child wins only when strictly larger than the left.
            if (cmp_gt) begin
               best_in     = rd_key;
               best_pos_in = best_pos_ff + 1'b1;
            end
            state_in = ST_DN_CMP_K;
         end

         ST_DN_CMP_K: begin
            mem_wr_en = 1'b1;
            if (cmp_gt) begin
               mem_wr_data = best_ff;
               if (pos_ff == COUNT_W'(1)) begin
                  top_in = best_ff;
               end
               pos_in   = best_pos_ff;
               state_in = ST_DN_READ_L;
            end else begin
               if (pos_ff == COUNT_W'(1)) begin
                  top_in = key_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.removed_value = removed_field;
      rsp_data.top_value     = (count_ff == '0) ? '0 : top_field;
      rsp_data.element_count = COUNT_FIELD_W'(count_ff);
   end

endmodule

>>> rtl/binary_max_heap_priority_queue_unit.sv
// Binary max-heap priority queue: top level tying the sift sequencer to the key memory.
// An item is taken when start is high and busy is low. Its result shows on rsp_data for
// exactly one cycle with rsp_valid high, and the receiver must take it as it comes. Busy is
// high from the cycle after the item is taken up to the cycle before its result shows.
// Three cases are answered straight from the idle state without a memory access, so busy
// stays low for them: a rejected insert, an extract from an empty heap, and an extract of
// the only key. An insert lets the new key climb from the new leaf until its parent is not
// smaller or it reaches the root. Each level it moves costs one parent read and one compare.
// An extract moves the last key to the root and sifts it down until it rests on a leaf or
// above children that are not larger. The sift-down step reads the two children one after
// the other through the single memory read port; a node with only a left child skips the
// second read. The next item can be started in the cycle in which the result is shown.
// The memory needs no clearing after reset. The root key is kept in a register, so the top
// of the heap costs no extra read.
module binary_max_heap_priority_queue_unit #(
   parameter int CAPACITY  = bmhpq_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = bmhpq_pkg::DEF_KEY_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bmhpq_pkg::req_type req_data,
   output logic               rsp_valid,
   output bmhpq_pkg::rsp_type rsp_data
);

   import bmhpq_pkg::*;

   localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [KEY_WIDTH-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [KEY_WIDTH-1:0] mem_rd_data;

   bmhpq_ctrl #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH),
      .ADDR_W    (ADDR_W),
      .COUNT_W   (COUNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   bmhpq_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W),
      .DATA_W (KEY_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
